[design/utf8_boundary_holdback_defines.svh]
// Assertion macros shared by the UTF-8 boundary holdback design.
`ifndef UTF8_BOUNDARY_HOLDBACK_DEFINES_SVH
`define UTF8_BOUNDARY_HOLDBACK_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define UBH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("UBH assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define UBH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("UBH assertion failed");
`else
`define UBH_ASSERT_IMPL(lbl, ante, cons)
`define UBH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/ubh_pkg.sv]
// Shared types, constants and functions of the UTF-8 boundary holdback design.
package ubh_pkg;

  localparam int unsigned HOLD_DEPTH = 3;
  localparam int unsigned BUF_DEPTH  = 4;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_AW       = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW       = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD1_VAL  = 8'h00;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;

  localparam logic FUNC_DATA    = 1'b0;
  localparam logic FUNC_DISCARD = 1'b1;

  // One released group: up to four bytes and the index of the last one.
  typedef struct packed {
    logic [BUF_DEPTH-1:0][7:0] data;
    logic [1:0]                last_idx;
  } pkt_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [1:0] held_cnt;
  } front_status_t;

  // Sequence length announced by a lead byte, zero when it is no valid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if ((c & LEAD1_MASK) == LEAD1_VAL)      len = 3'd1;
    else if ((c & LEAD2_MASK) == LEAD2_VAL) len = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_VAL) len = 3'd3;
    else if ((c & LEAD4_MASK) == LEAD4_VAL) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & CONT_MASK) == CONT_VAL;
  endfunction

endpackage

[design/ubh_front.sv]
// Front end: accepts words, keeps the held tail and finds the releasable prefix.
module ubh_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic                   func,
  input  logic [7:0]             in_byte,
  output ubh_pkg::push_t         push,
  output ubh_pkg::front_status_t status
);
  import ubh_pkg::*;

  logic [7:0] held_r [HOLD_DEPTH];
  logic [7:0] held_nxt [HOLD_DEPTH];
  logic [1:0] held_cnt_r, held_cnt_nxt;

  logic [BUF_DEPTH-1:0][7:0] buf_w;
  logic [2:0]                n_w;
  logic [2:0]                rel_w;

  // Build the four-byte buffer and scan it from the start.
  always_comb begin
    logic [2:0] pos;
    logic       stop;
    logic [2:0] len;
    logic       good;
    logic [2:0] idx;
    logic [3:0] sum;
    len  = 3'd0;
    good = 1'b0;
    idx  = 3'd0;
    sum  = 4'd0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (i < HOLD_DEPTH && 2'(i) < held_cnt_r) buf_w[i] = held_r[i];
      else if (3'(i) == {1'b0, held_cnt_r})    buf_w[i] = in_byte;
      else                                     buf_w[i] = 8'h00;
    end
    n_w  = {1'b0, held_cnt_r} + 3'd1;
    pos  = 3'd0;
    stop = 1'b0;
    for (int s = 0; s < BUF_DEPTH; s++) begin
      if (!stop && pos < n_w) begin
        len = lead_len(buf_w[pos[1:0]]);
        sum = {1'b0, pos} + {1'b0, len};
        if (len == 3'd0) begin
          pos = pos + 3'd1;
        end else if (sum > {1'b0, n_w}) begin
          stop = 1'b1;
        end else begin
          good = 1'b1;
          for (int k = 1; k < BUF_DEPTH; k++) begin
            idx = pos + 3'(k);
            if (3'(k) < len && !is_cont(buf_w[idx[1:0]])) good = 1'b0;
          end
          pos = good ? sum[2:0] : pos + 3'd1;
        end
      end
    end
    rel_w = pos;
  end

  // The tail after the released prefix becomes the new held bytes; a discard word clears them.
  always_comb begin
    logic [2:0] idx;
    logic [2:0] left;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      idx         = rel_w + 3'(i);
      held_nxt[i] = buf_w[idx[1:0]];
    end
    left = n_w - rel_w;
    if (func == FUNC_DISCARD) held_cnt_nxt = 2'd0;
    else                      held_cnt_nxt = left[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
    end else if (acc) begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && func == FUNC_DATA) begin
      for (int i = 0; i < HOLD_DEPTH; i++) held_r[i] <= held_nxt[i];
    end
  end

  always_comb begin
    logic [2:0] last;
    last              = rel_w - 3'd1;
    push.valid        = acc && func == FUNC_DATA && rel_w != 3'd0;
    push.pkt.data     = buf_w;
    push.pkt.last_idx = last[1:0];
    status.held_cnt   = held_cnt_r;
  end

endmodule

[design/ubh_queue.sv]
// Short packet queue between the front end and the output sequencer.
module ubh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  ubh_pkg::push_t     push,
  input  logic               pop,
  output ubh_pkg::pkt_t      head,
  output ubh_pkg::q_status_t status
);
  import ubh_pkg::*;

  pkt_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign do_push = push.valid && !status.full;
  assign do_pop  = pop && !status.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + Q_CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.pkt;
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = cnt_r == Q_CW'(Q_DEPTH);
  assign status.empty = cnt_r == '0;

endmodule

[design/ubh_back.sv]
// Back end: sends the bytes of each queued packet one word per cycle while out_tready is high.
module ubh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ubh_pkg::pkt_t      head,
  input  ubh_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  import ubh_pkg::*;

  logic       tvalid_r;
  logic [7:0] tdata_r;
  logic       tlast_r;
  logic [1:0] idx_r;
  logic       load;
  logic       is_last;

  assign load    = !q_status.empty && (!tvalid_r || out_tready);
  assign is_last = idx_r == head.last_idx;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      if (load) begin
        tvalid_r <= 1'b1;
        idx_r    <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= head.data[idx_r];
      tlast_r <= is_last;
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;
  assign out_tlast  = tlast_r;

endmodule

[design/utf8_boundary_holdback.sv]
// Top level of the UTF-8 boundary holdback: front end, packet queue, output sequencer.
//
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    in_tdata = in_byte, in_tuser = func
// out_      out  out_tvalid/out_tready  out_tdata = out_byte, out_tlast = last_of_run
//
// A word is taken every cycle while the four-entry packet queue has room; the
// front end resolves the held tail and the releasable prefix in the cycle of
// acceptance. The output sequencer sends one byte per cycle while out_tready is
// high, and the output port sets the sustained rate at one released byte per
// cycle.
// Reset (rst_n low, synchronous) empties the queue, drops the held bytes and
// clears the output valid. Output stalls back up through the queue to in_tready.
`include "utf8_boundary_holdback_defines.svh"

module utf8_boundary_holdback (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] func: 0 = data byte, 1 = discard held bytes
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import ubh_pkg::*;

  logic          in_acc;
  push_t         push;
  front_status_t front_st;
  pkt_t          head;
  q_status_t     q_st;
  logic          pop;

  // The front end never stalls on its own; room in the queue is the only gate.
  assign in_tready = !q_st.full;
  assign in_acc    = in_tvalid && in_tready;

  ubh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .func    (in_tuser[0]),
    .in_byte (in_tdata),
    .push    (push),
    .status  (front_st)
  );

  // Each entry is one word's released prefix, with the index of its last byte.
  ubh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_st)
  );

  ubh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_st),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A discard word leaves no held bytes behind.
  `UBH_ASSERT_NEXT(a_discard_clears, in_acc && in_tuser[0] == FUNC_DISCARD, front_st.held_cnt == 2'd0)
  // The sequencer only retires a packet that is really in the queue.
  `UBH_ASSERT_IMPL(a_pop_nonempty, pop, !q_st.empty)
  // The queue cannot be both full and empty.
  `UBH_ASSERT_IMPL(a_q_sane, q_st.full, !q_st.empty)

endmodule

[sim/utf8_boundary_holdback_test.sv]
// Self-checking testbench for the UTF-8 boundary holdback block.
module utf8_boundary_holdback_test;
  import ubh_pkg::*;

  // The run is cut off here.
  localparam int CYCLE_LIMIT = 60000;
  localparam int RANDOM_WORDS = 196;
  // Cycles allowed after the last expected byte for stray output to show up.
  localparam int DRAIN_CYCLES = 24;

  // One input word: the function code and the stream byte.
  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } stream_word_t;

  // One released byte as the output channel should carry it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } released_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic [0:0] in_tuser = 1'b0;    // [0] func
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;

  stream_word_t   word_q[$];
  released_byte_t release_q[$];

  // Predictor state: the tail of the stream that is still waiting for more bytes.
  logic [7:0] held_tail [3];
  int         held_len = 0;

  int send_idle_pct = 24;
  int recv_idle_pct = 51;
  int words_total = 0;
  int words_taken = 0;
  int discards_taken = 0;
  int bytes_checked = 0;
  int error_count = 0;
  int cycle_count = 0;

  utf8_boundary_holdback DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // Length a lead byte announces, or zero when the byte cannot start a sequence.
  function automatic int seq_len(input logic [7:0] c);
    casez (c)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic logic is_continuation(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

  // Appends one word to the held tail, releases the complete prefix into the
  // queue of expected bytes and keeps the rest as the new tail.
  task automatic predict_release(input logic func, input logic [7:0] data);
    logic [7:0] scan [4];
    int n;
    int pos;
    int len;
    int k;
    bit good;
    if (func == FUNC_DISCARD) begin
      held_len = 0;
      return;
    end
    for (k = 0; k < held_len; k++) scan[k] = held_tail[k];
    scan[held_len] = data;
    n = held_len + 1;
    pos = 0;
    while (pos < n) begin
      len = seq_len(scan[pos]);
      if (len == 0) begin
        pos++;
      end else if (pos + len > n) begin
        // A lead whose sequence runs past the buffer holds everything from
        // here on, even a byte that is already known not to fit.
        break;
      end else begin
        good = 1'b1;
        for (k = 1; k < len; k++)
          if (!is_continuation(scan[pos + k])) good = 1'b0;
        pos += good ? len : 1;
      end
    end
    for (k = 0; k < pos; k++)
      release_q.push_back('{data: scan[k], last: (k == pos - 1)});
    held_len = 0;
    for (k = pos; k < n && held_len < 3; k++) begin
      held_tail[held_len] = scan[k];
      held_len++;
    end
  endtask

  task automatic report_error(input string msg);
    if (error_count < 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic push_word(input logic func, input logic [7:0] data);
    word_q.push_back('{func: func, data: data});
    words_total++;
  endtask

  // Appends one well-formed character of the given length with random payload bits.
  task automatic push_char(input int len);
    int k;
    case (len)
      1: push_word(FUNC_DATA, {1'b0, 7'($urandom)});
      2: push_word(FUNC_DATA, {3'b110, 5'($urandom)});
      3: push_word(FUNC_DATA, {4'b1110, 4'($urandom)});
      default: push_word(FUNC_DATA, {5'b11110, 3'($urandom)});
    endcase
    for (k = 1; k < len; k++) push_word(FUNC_DATA, {2'b10, 6'($urandom)});
  endtask

  // Driver: presents the head of the word queue and drops it once it is taken.
  // Each output gets at most one assignment per edge, so a word that follows
  // directly on an accepted one keeps in_tvalid high without a glitch.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) void'(word_q.pop_front());
      if (!in_tvalid || in_tready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= word_q[0].data;
          in_tuser  <= word_q[0].func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predicts on every accepted input word, then checks every accepted
  // output byte against the oldest expectation. Prediction comes first so a
  // byte released in the same cycle as its word would still find its entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_release(in_tuser[0], in_tdata);
        words_taken++;
        if (in_tuser[0] == FUNC_DISCARD) discards_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (release_q.size() == 0) begin
          report_error($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          if (out_tdata !== release_q[0].data)
            report_error($sformatf("out_byte expected %02h actual %02h",
                                   release_q[0].data, out_tdata));
          if (out_tlast !== release_q[0].last)
            report_error($sformatf("last_of_run expected %0b actual %0b (byte %02h)",
                                   release_q[0].last, out_tlast, release_q[0].data));
          void'(release_q.pop_front());
        end
        bytes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, release_q.size());
      $display("[utf8_boundary_holdback] ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int len;
    int k;
    int random_words;

    // Directed part. Single-byte characters at both ends of the ASCII range.
    push_word(FUNC_DATA, 8'h00);
    push_word(FUNC_DATA, 8'h7F);
    // Complete two, three and four byte sequences.
    push_word(FUNC_DATA, 8'hC3); push_word(FUNC_DATA, 8'hA9);
    push_word(FUNC_DATA, 8'hE2); push_word(FUNC_DATA, 8'h82); push_word(FUNC_DATA, 8'hAC);
    push_word(FUNC_DATA, 8'hF0); push_word(FUNC_DATA, 8'h9F);
    push_word(FUNC_DATA, 8'h98); push_word(FUNC_DATA, 8'h80);
    // Bytes that cannot lead a sequence pass straight through.
    push_word(FUNC_DATA, 8'h80);
    push_word(FUNC_DATA, 8'hFF);
    push_word(FUNC_DATA, 8'hF8);
    // A two byte lead followed by ASCII breaks and goes out alone.
    push_word(FUNC_DATA, 8'hC3); push_word(FUNC_DATA, 8'h41);
    // A three byte lead stays held over a bad byte until the buffer is long
    // enough to see that the sequence is broken.
    push_word(FUNC_DATA, 8'hE2); push_word(FUNC_DATA, 8'h41); push_word(FUNC_DATA, 8'h42);
    // Discard with bytes held, then with nothing held and a nonzero byte.
    push_word(FUNC_DATA, 8'hF0); push_word(FUNC_DATA, 8'h90);
    push_word(FUNC_DISCARD, 8'hFF);
    push_word(FUNC_DISCARD, 8'hAA);
    // A lead after a discard starts from an empty tail.
    push_word(FUNC_DATA, 8'hC2); push_word(FUNC_DATA, 8'h80);

    // Random part: mostly well-formed text, some cut-off sequences, discards
    // and raw bytes that land anywhere in a sequence.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      k = words_total;
      r = $urandom_range(99);
      if (r < 65) begin
        push_char($urandom_range(1, 4));
      end else if (r < 78) begin
        len = $urandom_range(2, 4);
        case (len)
          2: push_word(FUNC_DATA, {3'b110, 5'($urandom)});
          3: push_word(FUNC_DATA, {4'b1110, 4'($urandom)});
          default: push_word(FUNC_DATA, {5'b11110, 3'($urandom)});
        endcase
        repeat ($urandom_range(0, len - 2)) push_word(FUNC_DATA, {2'b10, 6'($urandom)});
      end else if (r < 85) begin
        push_word(FUNC_DISCARD, 8'($urandom));
      end else begin
        push_word(FUNC_DATA, 8'($urandom));
      end
      random_words += words_total - k;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Idle pattern changes by progress: sender light and receiver heavy first,
    // then the reverse, then both sides at full rate.
    while (words_taken < words_total / 3) @(posedge clk);
    send_idle_pct = 51;
    recv_idle_pct = 24;
    while (words_taken < (2 * words_total) / 3) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (word_q.size() != 0 || release_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // Every predicted byte must have come out by now.
    if (release_q.size() != 0)
      report_error($sformatf("%0d expected bytes never came out", release_q.size()));

    $display("covered %0d words (%0d discards), %0d released bytes checked, %0d cycles",
             words_taken, discards_taken, bytes_checked, cycle_count);
    $display("idle mixes: sender 24%%/receiver 51%%, then 51%%/24%%, then none; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("[utf8_boundary_holdback] OK");
    end else begin
      $display("[utf8_boundary_holdback] ERROR");
    end
    $finish;
  end

endmodule
